/* design/qlsf_pkg.sv */
// ----------------------------------------------------------------------------
// qlsf_pkg: shared types and constants of the quadratic least-squares fit
// Field widths, operand and destination codes of the microcode, status codes
// and the microcode program of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package qlsf_pkg;

  // point fields
  localparam int unsigned W_X   = 14;
  // running sums (sized for the largest list); S2, S4 and XX are never negative
  localparam int unsigned W_S1  = 24;
  localparam int unsigned W_S2  = 37;
  localparam int unsigned W_S3  = 50;
  localparam int unsigned W_S4  = 63;
  localparam int unsigned W_T0  = 24;
  localparam int unsigned W_T1  = 38;
  localparam int unsigned W_T2  = 50;
  localparam int unsigned W_XX  = 27;
  localparam int unsigned W_X3  = 40;
  // wide datapath for cofactors and determinants
  localparam int unsigned WIDE_W = 128;
  localparam int unsigned DIG_W  = 8;
  localparam int unsigned NDIG   = WIDE_W / DIG_W;
  localparam int unsigned ND_W   = $clog2(NDIG + 1);
  localparam int unsigned COEF_W = 64;
  localparam int unsigned PC_W   = 5;

  // program counter landmarks
  localparam logic [PC_W-1:0] PC_PT_END = PC_W'(5);
  localparam logic [PC_W-1:0] PC_SOLVE  = PC_W'(5);
  localparam logic [PC_W-1:0] PC_END    = PC_W'(29);

  localparam logic [ND_W-1:0] ND_PT   = ND_W'(2);
  localparam logic [ND_W-1:0] ND_FULL = ND_W'(NDIG);

  // result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_SING = 2'd2;
  localparam logic [1:0] ST_MANY = 2'd3;

  typedef enum logic [4:0] {
    OPD_X, OPD_Y, OPD_XX, OPD_X3, OPD_N,
    OPD_S1, OPD_S2, OPD_S3, OPD_S4,
    OPD_T0, OPD_T1, OPD_T2,
    OPD_C0, OPD_C1, OPD_C2, OPD_E1, OPD_E2, OPD_E3
  } opnd_t;

  typedef enum logic [4:0] {
    DST_NONE, DST_XX, DST_X3, DST_S4, DST_T1, DST_T2,
    DST_C0, DST_C1, DST_C2, DST_E1, DST_E2, DST_E3,
    DST_D, DST_N0, DST_N1, DST_N2
  } dst_t;

  typedef struct packed {
    opnd_t           a;
    opnd_t           b;
    logic [ND_W-1:0] ndig;
    logic            init;
    logic            neg;
    dst_t            dst;
  } uop_t;

  // command to the multiply-accumulate unit
  typedef struct packed {
    logic              start;
    logic [WIDE_W-1:0] a;
    logic [WIDE_W-1:0] b;
    logic [ND_W-1:0]   ndig;
    logic              init;
    logic              neg;
  } mac_cmd_t;

  function automatic uop_t mk(opnd_t a, opnd_t b, logic [ND_W-1:0] nd,
                              logic init, logic neg, dst_t dst);
    uop_t u;
    u.a = a; u.b = b; u.ndig = nd; u.init = init; u.neg = neg; u.dst = dst;
    return u;
  endfunction

  // Per point: powers of x and cross terms. Per list: cofactors C, E,
  // then D and the three Cramer numerators (symmetric normal matrix).
  function automatic uop_t uc_rom(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      5'd0:  u = mk(OPD_X,  OPD_X,  ND_PT,   1'b1, 1'b0, DST_XX);
      5'd1:  u = mk(OPD_XX, OPD_X,  ND_PT,   1'b1, 1'b0, DST_X3);
      5'd2:  u = mk(OPD_X3, OPD_X,  ND_PT,   1'b1, 1'b0, DST_S4);
      5'd3:  u = mk(OPD_Y,  OPD_X,  ND_PT,   1'b1, 1'b0, DST_T1);
      5'd4:  u = mk(OPD_XX, OPD_Y,  ND_PT,   1'b1, 1'b0, DST_T2);
      5'd5:  u = mk(OPD_S2, OPD_N,  ND_FULL, 1'b1, 1'b0, DST_NONE);
      5'd6:  u = mk(OPD_S1, OPD_S1, ND_FULL, 1'b0, 1'b1, DST_C0);
      5'd7:  u = mk(OPD_S3, OPD_N,  ND_FULL, 1'b1, 1'b0, DST_NONE);
      5'd8:  u = mk(OPD_S1, OPD_S2, ND_FULL, 1'b0, 1'b1, DST_C1);
      5'd9:  u = mk(OPD_S3, OPD_S1, ND_FULL, 1'b1, 1'b0, DST_NONE);
      5'd10: u = mk(OPD_S2, OPD_S2, ND_FULL, 1'b0, 1'b1, DST_C2);
      5'd11: u = mk(OPD_S4, OPD_N,  ND_FULL, 1'b1, 1'b0, DST_NONE);
      5'd12: u = mk(OPD_S2, OPD_S2, ND_FULL, 1'b0, 1'b1, DST_E1);
      5'd13: u = mk(OPD_S4, OPD_S1, ND_FULL, 1'b1, 1'b0, DST_NONE);
      5'd14: u = mk(OPD_S2, OPD_S3, ND_FULL, 1'b0, 1'b1, DST_E2);
      5'd15: u = mk(OPD_S4, OPD_S2, ND_FULL, 1'b1, 1'b0, DST_NONE);
      5'd16: u = mk(OPD_S3, OPD_S3, ND_FULL, 1'b0, 1'b1, DST_E3);
      5'd17: u = mk(OPD_S4, OPD_C0, ND_FULL, 1'b1, 1'b0, DST_NONE);
      5'd18: u = mk(OPD_S3, OPD_C1, ND_FULL, 1'b0, 1'b1, DST_NONE);
      5'd19: u = mk(OPD_S2, OPD_C2, ND_FULL, 1'b0, 1'b0, DST_D);
      5'd20: u = mk(OPD_T2, OPD_C0, ND_FULL, 1'b1, 1'b0, DST_NONE);
      5'd21: u = mk(OPD_T1, OPD_C1, ND_FULL, 1'b0, 1'b1, DST_NONE);
      5'd22: u = mk(OPD_T0, OPD_C2, ND_FULL, 1'b0, 1'b0, DST_N0);
      5'd23: u = mk(OPD_T2, OPD_C1, ND_FULL, 1'b1, 1'b1, DST_NONE);
      5'd24: u = mk(OPD_T1, OPD_E1, ND_FULL, 1'b0, 1'b0, DST_NONE);
      5'd25: u = mk(OPD_T0, OPD_E2, ND_FULL, 1'b0, 1'b1, DST_N1);
      5'd26: u = mk(OPD_T2, OPD_C2, ND_FULL, 1'b1, 1'b0, DST_NONE);
      5'd27: u = mk(OPD_T1, OPD_E2, ND_FULL, 1'b0, 1'b1, DST_NONE);
      5'd28: u = mk(OPD_T0, OPD_E3, ND_FULL, 1'b0, 1'b0, DST_N2);
      default: u = mk(OPD_X, OPD_X, ND_PT, 1'b1, 1'b0, DST_NONE);
    endcase
    return u;
  endfunction

endpackage

/* design/qlsf_mac.sv */
// ----------------------------------------------------------------------------
// qlsf_mac: shared multiply-accumulate unit
// acc = (init ? 0 : acc) +/- a * b, modulo 2^128, taking one 8-bit digit of b
// per cycle; the top digit used is signed.
// ----------------------------------------------------------------------------
module qlsf_mac
  import qlsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mac_cmd_t          cmd,
  output logic              done,
  output logic [WIDE_W-1:0] acc
);

  logic [WIDE_W-1:0] a_r, b_r, acc_r;
  logic [ND_W-1:0]   cnt_r, ndig_r;
  logic              neg_r, busy_r, done_r;
  logic              last_dig;
  logic signed [DIG_W:0]   sdig;
  logic signed [DIG_W+1:0] ndig_val;
  logic signed [WIDE_W+DIG_W+1:0] prod;

  // digit select and one partial product
  always_comb begin
    last_dig = (cnt_r == ndig_r - ND_W'(1));
    sdig     = last_dig ? $signed({b_r[DIG_W-1], b_r[DIG_W-1:0]})
                        : $signed({1'b0, b_r[DIG_W-1:0]});
    ndig_val = neg_r ? -(DIG_W+2)'(sdig) : (DIG_W+2)'(sdig);
    prod     = $signed(a_r) * ndig_val;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last_dig;
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last_dig) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r    <= cmd.a;
      b_r    <= cmd.b;
      ndig_r <= cmd.ndig;
      neg_r  <= cmd.neg;
      cnt_r  <= '0;
      if (cmd.init) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      acc_r <= acc_r + prod[WIDE_W-1:0];
      a_r   <= a_r << DIG_W;
      b_r   <= b_r >> DIG_W;
      cnt_r <= cnt_r + ND_W'(1);
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

/* design/qlsf_div.sv */
// ----------------------------------------------------------------------------
// qlsf_div: serial signed quotient with scaling, rounding and saturation
// quo = round(num * 2^FRAC / den), ties away from zero, clamped to 64 bits.
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qlsf_div
  import qlsf_pkg::*;
#(
  parameter int FRAC = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WIDE_W-1:0] num,
  input  logic [WIDE_W-1:0] den,
  output logic              done,
  output logic [COEF_W-1:0] quo
);

  localparam int NW = WIDE_W + FRAC + 2;
  localparam int IW = $clog2(NW);
  localparam logic [IW-1:0] IDX_TOP = IW'(COEF_W - 1);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001, D_PREP = 4'b0010, D_RUN = 4'b0100, D_FIN = 4'b1000
  } dst_st_t;

  dst_st_t             st_r;
  logic [WIDE_W-1:0]   an_r, ad_r;
  logic [NW-1:0]       n_r;
  logic [WIDE_W:0]     den_r, rem_r;
  logic [WIDE_W:0]     rem_sh;
  logic [COEF_W-2:0]   q_r;
  logic [IW-1:0]       idx_r;
  logic                neg_r, ovf_r, ge, done_r;
  logic [COEF_W-1:0]   quo_r;

  // restoring step
  always_comb begin
    rem_sh = {rem_r[WIDE_W-1:0], n_r[NW-1]};
    ge     = (rem_sh >= den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        D_IDLE: if (start) st_r <= D_PREP;
        D_PREP: st_r <= D_RUN;
        D_RUN:  if (idx_r == '0) st_r <= D_FIN;
        D_FIN: begin
          done_r <= 1'b1;
          st_r   <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      D_IDLE: begin
        // magnitudes and result sign
        an_r  <= num[WIDE_W-1] ? -num : num;
        ad_r  <= den[WIDE_W-1] ? -den : den;
        neg_r <= num[WIDE_W-1] ^ den[WIDE_W-1];
      end
      D_PREP: begin
        n_r   <= ({{(NW-WIDE_W){1'b0}}, an_r} << (FRAC + 1))
                 + {{(NW-WIDE_W){1'b0}}, ad_r};
        den_r <= {ad_r, 1'b0};
        rem_r <= '0;
        idx_r <= IW'(NW - 1);
        ovf_r <= 1'b0;
        q_r   <= '0;
      end
      D_RUN: begin
        rem_r <= ge ? rem_sh - den_r : rem_sh;
        n_r   <= n_r << 1;
        q_r   <= {q_r[COEF_W-3:0], ge};
        if (ge && idx_r >= IDX_TOP) ovf_r <= 1'b1;
        idx_r <= idx_r - IW'(1);
      end
      D_FIN: begin
        if (ovf_r) begin
          quo_r <= neg_r ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        end else begin
          quo_r <= neg_r ? -{1'b0, q_r} : {1'b0, q_r};
        end
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* design/quadratic_least_squares_fit.sv */
// ----------------------------------------------------------------------------
// quadratic_least_squares_fit: y = a2*x^2 + a1*x + a0 over a list of points
// Accumulates power sums per point, then solves the normal equations by
// Cramer's rule on a shared multiply-accumulate unit and a serial divider.
// ----------------------------------------------------------------------------
// Each point word runs five products on the shared 128x8 multiply-accumulate
// unit, each by a 14-bit x or y of two digits, plus issue and write-back. A
// point beyond MAX_POINTS is accepted without products and marks the list as
// too long. The word flagged tlast is followed by the solve: 24 products of 16
// digits each for the cofactors, the determinant and three numerators, then
// three divisions in the serial divider. Lists with too few or too many points
// skip the solve; a singular list skips the divisions. in_tready is low while
// any of this runs; the result word sits in an output register, so one result
// may wait for the sink while the next list streams in.
module quadratic_least_squares_fit
  import qlsf_pkg::*;
#(
  parameter int MAX_POINTS      = 1024,
  parameter int COEFF_FRAC_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // x[13:0], y[27:14], zero fill
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // a2[63:0], a1[127:64], a0[191:128]
  output logic [1:0]   out_tuser   // status[1:0]
);

  localparam int CW = $clog2(MAX_POINTS + 2);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_POINTS);
  localparam logic [CW-1:0] CNT_OVER = CW'(MAX_POINTS + 1);
  localparam logic [CW-1:0] CNT_MIN  = CW'(3);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PMUL   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SOLVE  = 6'b001000,
    S_DIV    = 6'b010000,
    S_EMIT   = 6'b100000
  } st_t;

  st_t               st_r;
  logic [PC_W-1:0]   pc_r;
  logic              issued_r, last_r;
  logic [1:0]        div_idx_r;
  logic [W_X-1:0]    x_r, y_r;
  logic [CW-1:0]     cnt_r;
  logic [W_S1-1:0]   s1_r;
  logic [W_S2-1:0]   s2_r;
  logic [W_S3-1:0]   s3_r;
  logic [W_S4-1:0]   s4_r;
  logic [W_T0-1:0]   t0_r;
  logic [W_T1-1:0]   t1_r;
  logic [W_T2-1:0]   t2_r;
  logic [W_XX-1:0]   xx_r;
  logic [W_X3-1:0]   x3_r;
  logic [WIDE_W-1:0] c0_r, c1_r, c2_r, e1_r, e2_r, e3_r, d_r, n0_r, n1_r, n2_r;
  logic [COEF_W-1:0] a2_r, a1_r, a0_r;
  logic [1:0]        status_r;
  logic              out_tvalid_r;
  logic [191:0]      out_tdata_r;
  logic [1:0]        out_tuser_r;

  uop_t              uop;
  mac_cmd_t          mac_cmd;
  logic              mac_done, div_start, div_done;
  logic [WIDE_W-1:0] mac_acc, div_num;
  logic [COEF_W-1:0] div_quo;
  logic              in_acc, out_free;
  logic [W_X-1:0]    in_x, in_y;

  assign in_x     = in_tdata[W_X-1:0];
  assign in_y     = in_tdata[2*W_X-1:W_X];
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign uop      = uc_rom(pc_r);

  // operand select for the shared unit
  function automatic logic [WIDE_W-1:0] opnd(opnd_t sel);
    logic [WIDE_W-1:0] v;
    unique case (sel)
      OPD_X:  v = {{(WIDE_W-W_X){x_r[W_X-1]}}, x_r};
      OPD_Y:  v = {{(WIDE_W-W_X){y_r[W_X-1]}}, y_r};
      OPD_XX: v = {{(WIDE_W-W_XX){1'b0}}, xx_r};
      OPD_X3: v = {{(WIDE_W-W_X3){x3_r[W_X3-1]}}, x3_r};
      OPD_N:  v = {{(WIDE_W-CW){1'b0}}, cnt_r};
      OPD_S1: v = {{(WIDE_W-W_S1){s1_r[W_S1-1]}}, s1_r};
      OPD_S2: v = {{(WIDE_W-W_S2){1'b0}}, s2_r};
      OPD_S3: v = {{(WIDE_W-W_S3){s3_r[W_S3-1]}}, s3_r};
      OPD_S4: v = {{(WIDE_W-W_S4){1'b0}}, s4_r};
      OPD_T0: v = {{(WIDE_W-W_T0){t0_r[W_T0-1]}}, t0_r};
      OPD_T1: v = {{(WIDE_W-W_T1){t1_r[W_T1-1]}}, t1_r};
      OPD_T2: v = {{(WIDE_W-W_T2){t2_r[W_T2-1]}}, t2_r};
      OPD_C0: v = c0_r;
      OPD_C1: v = c1_r;
      OPD_C2: v = c2_r;
      OPD_E1: v = e1_r;
      OPD_E2: v = e2_r;
      OPD_E3: v = e3_r;
      default: v = '0;
    endcase
    return v;
  endfunction

  // command to the shared unit
  always_comb begin
    mac_cmd.start = ((st_r == S_PMUL) || (st_r == S_SOLVE)) && !issued_r;
    mac_cmd.a     = opnd(uop.a);
    mac_cmd.b     = opnd(uop.b);
    mac_cmd.ndig  = uop.ndig;
    mac_cmd.init  = uop.init;
    mac_cmd.neg   = uop.neg;
  end

  always_comb begin
    unique case (div_idx_r)
      2'd0:    div_num = n0_r;
      2'd1:    div_num = n1_r;
      default: div_num = n2_r;
    endcase
  end
  assign div_start = (st_r == S_DIV) && !issued_r;

  qlsf_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (mac_cmd),
    .done (mac_done),
    .acc  (mac_acc)
  );

  qlsf_div #(.FRAC(COEFF_FRAC_BITS)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (d_r),
    .done (div_done),
    .quo  (div_quo)
  );

  // sequencer and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      pc_r         <= '0;
      issued_r     <= 1'b0;
      div_idx_r    <= '0;
      cnt_r        <= '0;
      s1_r         <= '0;
      s2_r         <= '0;
      s3_r         <= '0;
      s4_r         <= '0;
      t0_r         <= '0;
      t1_r         <= '0;
      t2_r         <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            x_r    <= in_x;
            y_r    <= in_y;
            last_r <= in_tlast;
            if (cnt_r < CNT_MAX) begin
              cnt_r    <= cnt_r + CW'(1);
              s1_r     <= s1_r + {{(W_S1-W_X){in_x[W_X-1]}}, in_x};
              t0_r     <= t0_r + {{(W_T0-W_X){in_y[W_X-1]}}, in_y};
              pc_r     <= '0;
              issued_r <= 1'b0;
              st_r     <= S_PMUL;
            end else begin
              cnt_r <= CNT_OVER;
              if (in_tlast) st_r <= S_DECIDE;
            end
          end
        end
        S_PMUL, S_SOLVE: begin
          if (mac_cmd.start) issued_r <= 1'b1;
          if (mac_done) begin
            issued_r <= 1'b0;
            pc_r     <= pc_r + PC_W'(1);
            unique case (uop.dst)
              DST_XX: begin
                xx_r <= mac_acc[W_XX-1:0];
                s2_r <= s2_r + mac_acc[W_S2-1:0];
              end
              DST_X3: begin
                x3_r <= mac_acc[W_X3-1:0];
                s3_r <= s3_r + mac_acc[W_S3-1:0];
              end
              DST_S4: s4_r <= s4_r + mac_acc[W_S4-1:0];
              DST_T1: t1_r <= t1_r + mac_acc[W_T1-1:0];
              DST_T2: t2_r <= t2_r + mac_acc[W_T2-1:0];
              DST_C0: c0_r <= mac_acc;
              DST_C1: c1_r <= mac_acc;
              DST_C2: c2_r <= mac_acc;
              DST_E1: e1_r <= mac_acc;
              DST_E2: e2_r <= mac_acc;
              DST_E3: e3_r <= mac_acc;
              DST_D:  d_r  <= mac_acc;
              DST_N0: n0_r <= mac_acc;
              DST_N1: n1_r <= mac_acc;
              DST_N2: n2_r <= mac_acc;
              default: ;
            endcase
            if (st_r == S_PMUL && pc_r + PC_W'(1) == PC_PT_END) begin
              st_r <= last_r ? S_DECIDE : S_IDLE;
            end
            if (st_r == S_SOLVE && pc_r + PC_W'(1) == PC_END) begin
              // singular check happens on the next state entry
              div_idx_r <= '0;
              st_r      <= S_DIV;
            end
          end
        end
        S_DECIDE: begin
          a2_r <= '0;
          a1_r <= '0;
          a0_r <= '0;
          if (cnt_r == CNT_OVER) begin
            status_r <= ST_MANY;
            st_r     <= S_EMIT;
          end else if (cnt_r < CNT_MIN) begin
            status_r <= ST_FEW;
            st_r     <= S_EMIT;
          end else begin
            status_r <= ST_OK;
            pc_r     <= PC_SOLVE;
            issued_r <= 1'b0;
            st_r     <= S_SOLVE;
          end
        end
        S_DIV: begin
          if (!issued_r && d_r == '0) begin
            status_r <= ST_SING;
            st_r     <= S_EMIT;
          end else begin
            if (div_start) issued_r <= 1'b1;
            if (div_done) begin
              issued_r  <= 1'b0;
              div_idx_r <= div_idx_r + 2'd1;
              unique case (div_idx_r)
                2'd0:    a2_r <= div_quo;
                2'd1:    a1_r <= div_quo;
                default: a0_r <= div_quo;
              endcase
              if (div_idx_r == 2'd2) st_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_tdata_r  <= {a0_r, a1_r, a2_r};
            out_tuser_r  <= status_r;
            cnt_r <= '0;
            s1_r  <= '0;
            s2_r  <= '0;
            s3_r  <= '0;
            s4_r  <= '0;
            t0_r  <= '0;
            t1_r  <= '0;
            t2_r  <= '0;
            st_r  <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // result word valid: set on emit, cleared when the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((st_r == S_EMIT) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

/* design/qlsf_check.sv */
// ----------------------------------------------------------------------------
// qlsf_check: port-level checks for the quadratic fit
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module qlsf_check
  import qlsf_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata,
  input logic [1:0]   out_tuser
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // failed fits carry zero coefficients
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata == '0)
    else $error("nonzero coefficients with failure status");

  // the closing point of a list ends the idle state, so input stalls
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input ready right after closing point");

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind quadratic_least_squares_fit qlsf_check u_qlsf_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tlast  (in_tlast),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
